>>> rtl/core/qoi_pkg.sv
// ----------------------------------------------------------------------------
// qoi_pkg
// shared types, constants and helpers of the qoi image decoder
// ----------------------------------------------------------------------------
package qoi_pkg;

  localparam int unsigned IndexSlots = 64;
  localparam int unsigned IndexAw = $clog2(IndexSlots);
  localparam logic [31:0] MaxPixelsReset = 32'd400000000;

  localparam logic [2:0] StPixel    = 3'd0;
  localparam logic [2:0] StHeaderOk = 3'd1;
  localparam logic [2:0] StBadHdr   = 3'd2;
  localparam logic [2:0] StTooLarge = 3'd3;
  localparam logic [2:0] StTrunc    = 3'd4;

  localparam logic [7:0] OpRgb  = 8'hFE;
  localparam logic [7:0] OpRgba = 8'hFF;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_PIXELS,
    MODE_IDLE
  } mode_t;

  typedef enum logic [2:0] {
    FSM_IN,
    FSM_IDX_WAIT,
    FSM_EMIT,
    FSM_MUL,
    FSM_STATUS,
    FSM_TRUNC
  } fsm_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] a;
    logic       last;
    logic       run_end;
    logic [2:0] status;
    logic [31:0] w;
    logic [31:0] h;
  } result_t;

  // (c*a+127)/255 for 16-bit product plus rounding
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] p;
    logic [16:0] q;
    begin
      p = 17'(c) * 17'(a) + 17'd127;
      q = (p + (p >> 8) + 17'd1) >> 8;
      premul = q[7:0];
    end
  endfunction

  function automatic logic [IndexAw-1:0] hash(input logic [31:0] px);
    logic [11:0] s;
    begin
      s = 12'(px[31:24]) * 12'd3 + 12'(px[23:16]) * 12'd5
        + 12'(px[15:8]) * 12'd7 + 12'(px[7:0]) * 12'd11;
      hash = s[IndexAw-1:0];
    end
  endfunction

endpackage

>>> rtl/core/qoi_if.sv
// ----------------------------------------------------------------------------
// qoi_if
// valid/ready channels for input items, results and configuration
// ----------------------------------------------------------------------------
interface qoi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_image;
  logic       end_of_data;
  modport source (output valid, in_byte, start_image, end_of_data, input ready);
  modport sink (input valid, in_byte, start_image, end_of_data, output ready);
endinterface

interface qoi_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [7:0]  alpha;
  logic        last_pixel;
  logic        run_end;
  logic [2:0]  status;
  logic [31:0] image_width;
  logic [31:0] image_height;
  modport source (output valid, blue, green, red, alpha, last_pixel, run_end, status,
    image_width, image_height, input ready);
  modport sink (input valid, blue, green, red, alpha, last_pixel, run_end, status,
    image_width, image_height, output ready);
endinterface

interface qoi_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/qoi_image_decoder.sv
// ----------------------------------------------------------------------------
// qoi_image_decoder
// byte-serial qoi decoder with a 64-slot color index in a synchronous ram
// flow: a pixel byte passes the mul and emit states, an index op idx_wait,
// mul and emit; status and truncation items come from their own states, and
// a run repeats emit per pixel; a byte with no item keeps the in state; bytes
// are taken only in the in state, and each item waits for room in the output reg
// reset: synchronous; index slots read as zero until written, through per-slot
// valid bits that are cleared at reset and at each image start
// ----------------------------------------------------------------------------
module qoi_image_decoder (
  input  logic      clk,
  input  logic      rst,
  qoi_in_if.sink    in_ch,
  qoi_cfg_if.sink   cfg,
  qoi_out_if.source out_ch
);
  localparam int unsigned Aw = qoi_pkg::IndexAw;
  localparam int unsigned Slots = qoi_pkg::IndexSlots;

  logic [31:0]        max_pixels;
  qoi_pkg::mode_t     mode, mode_next;
  qoi_pkg::fsm_t      fsm, fsm_next;
  logic [31:0]        cur, cur_next;
  logic [31:0]        width_reg, width_next;
  logic [31:0]        height_reg, height_next;
  logic [31:0]        pixels_left, pixels_next;
  logic [3:0]         byte_phase, phase_next;
  logic [7:0]         op_byte, op_next;
  logic [5:0]         run_left, run_next;
  logic               eod, eod_next;
  logic [2:0]         stat, stat_next;
  logic [Slots-1:0]   slot_ok, slot_ok_next;
  logic               idx_ok;
  logic [63:0]        area;
  logic [63:0]        area_q;

  logic               we;
  logic [Aw-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;
  logic               full, push, slot_free;
  qoi_pkg::result_t   res;

  logic               acc;
  logic [7:0]         v;
  logic [7:0]         pr, pg, pb;
  logic [7:0]         dg;
  logic [7:0]         mag;
  qoi_pkg::mode_t     m_eff;
  logic [3:0]         ph_eff;
  logic [7:0]         op_eff;
  logic               last_px, more_run;
  logic               go_idx, go_emit, go_status, go_trunc;
  logic [1:0]         pos;

  qoi_ram #(.Width(32), .Depth(qoi_pkg::IndexSlots)) u_index (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  qoi_out_reg u_out (
    .clk(clk), .rst(rst), .push(push), .res(res), .full(full), .out(out_ch)
  );

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (fsm == qoi_pkg::FSM_IN);
  assign acc = in_ch.valid && in_ch.ready;
  assign v = in_ch.in_byte;
  assign raddr = v[Aw-1:0];
  assign area = 64'(width_reg) * 64'(height_reg);
  assign slot_free = !full || out_ch.ready;
  assign last_px = (pixels_left == 32'd1);
  assign more_run = (run_left != 6'd0) && !last_px;
  assign dg = {2'b00, op_byte[5:0]};

  // a start byte is decoded as header byte 0 of a cleared decoder
  assign m_eff = in_ch.start_image ? qoi_pkg::MODE_HEADER : mode;
  assign ph_eff = in_ch.start_image ? 4'd0 : byte_phase;
  assign op_eff = in_ch.start_image ? 8'd0 : op_byte;

  always_comb begin
    case (ph_eff[1:0])
      2'd0: mag = "q";
      2'd1: mag = "o";
      2'd2: mag = "i";
      default: mag = "f";
    endcase
  end

  // premultiplied color registered before the emit state; also the area and slot valid bit
  always_ff @(posedge clk) begin
    pr <= qoi_pkg::premul(cur[31:24], cur[7:0]);
    pg <= qoi_pkg::premul(cur[23:16], cur[7:0]);
    pb <= qoi_pkg::premul(cur[15:8], cur[7:0]);
    area_q <= area;
    idx_ok <= slot_ok[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pixels <= qoi_pkg::MaxPixelsReset;
    end else if (cfg.valid && cfg.ready) begin
      max_pixels <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= qoi_pkg::MODE_HEADER;
      fsm <= qoi_pkg::FSM_IN;
      cur <= 32'h0000_00FF;
      width_reg <= '0;
      height_reg <= '0;
      pixels_left <= '0;
      byte_phase <= '0;
      op_byte <= '0;
      run_left <= '0;
      eod <= 1'b0;
      stat <= qoi_pkg::StPixel;
      slot_ok <= '0;
    end else begin
      mode <= mode_next;
      fsm <= fsm_next;
      cur <= cur_next;
      width_reg <= width_next;
      height_reg <= height_next;
      pixels_left <= pixels_next;
      byte_phase <= phase_next;
      op_byte <= op_next;
      run_left <= run_next;
      eod <= eod_next;
      stat <= stat_next;
      slot_ok <= slot_ok_next;
    end
  end

  always_comb begin
    fsm_next = fsm;
    case (fsm)
      qoi_pkg::FSM_IN: begin
        if (go_idx) begin
          fsm_next = qoi_pkg::FSM_IDX_WAIT;
        end else if (go_emit) begin
          fsm_next = qoi_pkg::FSM_MUL;
        end else if (go_status) begin
          fsm_next = qoi_pkg::FSM_STATUS;
        end else if (go_trunc) begin
          fsm_next = qoi_pkg::FSM_TRUNC;
        end
      end
      qoi_pkg::FSM_IDX_WAIT: fsm_next = qoi_pkg::FSM_MUL;
      qoi_pkg::FSM_MUL: fsm_next = qoi_pkg::FSM_EMIT;
      qoi_pkg::FSM_EMIT: begin
        if (slot_free) begin
          if (more_run) begin
            fsm_next = qoi_pkg::FSM_EMIT;
          end else if (eod && !last_px) begin
            fsm_next = qoi_pkg::FSM_TRUNC;
          end else begin
            fsm_next = qoi_pkg::FSM_IN;
          end
        end
      end
      qoi_pkg::FSM_STATUS: begin
        if (slot_free) begin
          if (eod && mode == qoi_pkg::MODE_PIXELS) begin
            fsm_next = qoi_pkg::FSM_TRUNC;
          end else begin
            fsm_next = qoi_pkg::FSM_IN;
          end
        end
      end
      qoi_pkg::FSM_TRUNC: begin
        if (slot_free) begin
          fsm_next = qoi_pkg::FSM_IN;
        end
      end
      default: fsm_next = qoi_pkg::FSM_IN;
    endcase
  end

  always_comb begin
    mode_next = mode;
    cur_next = cur;
    width_next = width_reg;
    height_next = height_reg;
    pixels_next = pixels_left;
    phase_next = byte_phase;
    op_next = op_byte;
    run_next = run_left;
    eod_next = eod;
    stat_next = stat;
    slot_ok_next = slot_ok;
    we = 1'b0;
    waddr = qoi_pkg::hash(cur);
    wdata = cur;
    push = 1'b0;
    res = '0;
    go_idx = 1'b0;
    go_emit = 1'b0;
    go_status = 1'b0;
    go_trunc = 1'b0;
    pos = 2'd0;
    case (fsm)
      qoi_pkg::FSM_IN: begin
        if (acc) begin
          eod_next = in_ch.end_of_data;
          if (in_ch.start_image) begin
            cur_next = 32'h0000_00FF;
            width_next = '0;
            height_next = '0;
            pixels_next = '0;
            phase_next = '0;
            op_next = '0;
            mode_next = qoi_pkg::MODE_HEADER;
            slot_ok_next = '0;
          end
          case (m_eff)
            qoi_pkg::MODE_HEADER: begin
              op_next = op_eff;
              if (ph_eff < 4'd4) begin
                if (v != mag) op_next[0] = 1'b1;
              end else if (ph_eff < 4'd8) begin
                width_next = {width_reg[23:0], v};
              end else if (ph_eff < 4'd12) begin
                height_next = {height_reg[23:0], v};
              end else if (ph_eff == 4'd12) begin
                if (v < 8'd3 || v > 8'd4) op_next[0] = 1'b1;
              end
              if (ph_eff < 4'd13) begin
                phase_next = ph_eff + 4'd1;
                go_trunc = in_ch.end_of_data;
              end else begin
                phase_next = '0;
                op_next = '0;
                go_status = 1'b1;
                if (op_byte[0] || width_reg == 32'd0 || height_reg == 32'd0) begin
                  stat_next = qoi_pkg::StBadHdr;
                  mode_next = qoi_pkg::MODE_IDLE;
                end else if (area_q > {32'd0, max_pixels}) begin
                  stat_next = qoi_pkg::StTooLarge;
                  mode_next = qoi_pkg::MODE_IDLE;
                end else begin
                  stat_next = qoi_pkg::StHeaderOk;
                  pixels_next = area_q[31:0];
                  mode_next = qoi_pkg::MODE_PIXELS;
                end
              end
            end
            qoi_pkg::MODE_PIXELS: begin
              if (byte_phase != 4'd0) begin
                if (op_byte == qoi_pkg::OpRgb || op_byte == qoi_pkg::OpRgba) begin
                  pos = 2'(((op_byte == qoi_pkg::OpRgba) ? 4'd4 : 4'd3) - byte_phase);
                  case (pos)
                    2'd0: cur_next[31:24] = v;
                    2'd1: cur_next[23:16] = v;
                    2'd2: cur_next[15:8] = v;
                    default: cur_next[7:0] = v;
                  endcase
                  phase_next = byte_phase - 4'd1;
                  if (byte_phase == 4'd1) begin
                    go_emit = 1'b1;
                  end else begin
                    go_trunc = in_ch.end_of_data;
                  end
                end else begin
                  cur_next[31:24] = cur[31:24] + dg + 8'd216 + {4'd0, v[7:4]};
                  cur_next[23:16] = cur[23:16] + dg + 8'd224;
                  cur_next[15:8] = cur[15:8] + dg + 8'd216 + {4'd0, v[3:0]};
                  phase_next = '0;
                  go_emit = 1'b1;
                end
              end else if (v == qoi_pkg::OpRgb) begin
                op_next = v;
                phase_next = 4'd3;
                go_trunc = in_ch.end_of_data;
              end else if (v == qoi_pkg::OpRgba) begin
                op_next = v;
                phase_next = 4'd4;
                go_trunc = in_ch.end_of_data;
              end else begin
                case (v[7:6])
                  2'd0: go_idx = 1'b1;
                  2'd1: begin
                    cur_next[31:24] = cur[31:24] + {6'd0, v[5:4]} + 8'd254;
                    cur_next[23:16] = cur[23:16] + {6'd0, v[3:2]} + 8'd254;
                    cur_next[15:8] = cur[15:8] + {6'd0, v[1:0]} + 8'd254;
                    go_emit = 1'b1;
                  end
                  2'd2: begin
                    op_next = v;
                    phase_next = 4'd1;
                    go_trunc = in_ch.end_of_data;
                  end
                  default: begin
                    run_next = v[5:0];
                    go_emit = 1'b1;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      qoi_pkg::FSM_IDX_WAIT: begin
        cur_next = idx_ok ? rdata : 32'd0;
      end
      qoi_pkg::FSM_EMIT: begin
        if (slot_free) begin
          push = 1'b1;
          res.b = pb;
          res.g = pg;
          res.r = pr;
          res.a = cur[7:0];
          res.last = last_px;
          res.run_end = !more_run && !(eod && !last_px);
          res.status = qoi_pkg::StPixel;
          we = 1'b1;
          slot_ok_next[waddr] = 1'b1;
          pixels_next = pixels_left - 32'd1;
          if (last_px) mode_next = qoi_pkg::MODE_IDLE;
          run_next = more_run ? run_left - 6'd1 : 6'd0;
        end
      end
      qoi_pkg::FSM_STATUS: begin
        if (slot_free) begin
          push = 1'b1;
          res.status = stat;
          if (stat == qoi_pkg::StHeaderOk) begin
            res.w = width_reg;
            res.h = height_reg;
          end
          res.run_end = !(eod && mode == qoi_pkg::MODE_PIXELS);
        end
      end
      qoi_pkg::FSM_TRUNC: begin
        if (slot_free) begin
          push = 1'b1;
          res.status = qoi_pkg::StTrunc;
          res.run_end = 1'b1;
          mode_next = qoi_pkg::MODE_IDLE;
          phase_next = '0;
          op_next = '0;
        end
      end
      default: ;
    endcase
  end

  a_ready_in_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> fsm == qoi_pkg::FSM_IN);
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || out_ch.ready));
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status));
  a_write_emit: assert property (@(posedge clk) disable iff (rst)
    we |-> fsm == qoi_pkg::FSM_EMIT);
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode == qoi_pkg::MODE_HEADER || mode == qoi_pkg::MODE_PIXELS
      || mode == qoi_pkg::MODE_IDLE);

endmodule

>>> rtl/core/qoi_ram.sv
// ----------------------------------------------------------------------------
// qoi_ram
// generic simple dual-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module qoi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/qoi_out_reg.sv
// ----------------------------------------------------------------------------
// qoi_out_reg
// output register that holds one result item until taken
// ----------------------------------------------------------------------------
module qoi_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qoi_pkg::result_t  res,
  output logic              full,
  qoi_out_if.source         out
);
  qoi_pkg::result_t held;
  logic             pop;

  assign pop = out.valid && out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (pop) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

  assign out.valid        = full;
  assign out.blue         = held.b;
  assign out.green        = held.g;
  assign out.red          = held.r;
  assign out.alpha        = held.a;
  assign out.last_pixel   = held.last;
  assign out.run_end      = held.run_end;
  assign out.status       = held.status;
  assign out.image_width  = held.w;
  assign out.image_height = held.h;
endmodule
